/* rtl/core/dcam_pkg.sv */
// ----------------------------------------------------------------------------
// dcam_pkg: shared types and constants of the drive command arbiter mixer
// Fixed-point format, field widths, opcodes, source codes and the structs
// that travel between the command store, the sequencer and the multiplier.
// ----------------------------------------------------------------------------
package dcam_pkg;

    // Q format of speed, turn, gain and drive values
    localparam int FRAC_BITS = 12;

    localparam int OP_W      = 3;
    localparam int CMD_W     = 16;
    localparam int RANGE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int AGE_W     = 16;
    localparam int DRIVE_W   = 14;
    localparam int SRC_W     = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    localparam int ONE_Q    = 1 << FRAC_BITS;
    localparam int MIX_GAIN = ((8 << FRAC_BITS) + 5) / 10;

    // clamped value holds +/-ONE_Q, the mix sum twice that
    localparam int VAL_W   = FRAC_BITS + 2;
    localparam int SUM_W   = FRAC_BITS + 3;
    localparam int MUL_A_W = (SUM_W > CMD_W + 1) ? SUM_W : CMD_W + 1;
    localparam int MUL_B_W = CFG_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SHR_W   = PROD_W - FRAC_BITS;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [CFG_W-1:0] MANUAL_GAIN_RST = CFG_W'(1638);
    localparam logic [CFG_W-1:0] AUTO_GAIN_RST   = CFG_W'(6144);
    localparam logic [CFG_W-1:0] TIMEOUT_RST     = CFG_W'(20);
    localparam logic [CFG_W-1:0] SAFETY_RST      = CFG_W'(300);

    typedef enum logic [OP_W-1:0] {
        OP_MANUAL = 3'd0,
        OP_AUTO   = 3'd1,
        OP_STOP   = 3'd2,
        OP_MODE   = 3'd3,
        OP_TICK   = 3'd4
    } op_t;

    typedef enum logic [SRC_W-1:0] {
        SRC_NONE   = 2'd0,
        SRC_MANUAL = 2'd1,
        SRC_AUTO   = 2'd2
    } src_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MANUAL_GAIN = 3'd0,
        CFG_AUTO_GAIN   = 3'd1,
        CFG_TIMEOUT     = 3'd2,
        CFG_SAFETY      = 3'd3,
        CFG_FLIP_TURN   = 3'd4
    } cfg_idx_t;

    // command picked for the current tick
    typedef struct packed {
        logic signed [CMD_W-1:0] speed;
        logic signed [CMD_W-1:0] turn;
        logic [CFG_W-1:0]        scale;
        src_t                    src;
    } sel_t;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                      reverse_blocked;
        logic                      forward_blocked;
        src_t                      active_source;
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
    } result_t;

endpackage

/* rtl/core/drive_command_arbiter_mixer.sv */
// ----------------------------------------------------------------------------
// drive_command_arbiter_mixer: drive command arbiter and differential mixer
// Arbitrates manual and autonomous velocity commands with timeout, blocks
// motion toward near obstacles and mixes left and right wheel drives.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_ stream; s_tuser carries the opcode (manual
// command, autonomous command, stop button, auto-mode button, control tick).
// Command and button requests update the stored state and give
// no result. A control tick gives one result on the m_ stream.
// A tick is accepted, runs four multiplies on one shared multiplier (scale
// speed, scale turn, mix right, mix left) plus a clamp step, then loads the
// output register and raises m_tvalid; s_tready stays low until then, so no
// request is taken mid-tick; while idle, other requests go at one per cycle.
// The result sits in an output register: the next request is taken while it
// waits. When the receiver stalls, the following tick waits in its last step
// with s_tready low until the held result is taken.
// Reset (aresetn low, synchronous) restores the register defaults, clears both
// commands and ages, enters stopped and autonomous mode, and drops m_tvalid.
// The user must write registers through cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module drive_command_arbiter_mixer import dcam_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // linear_cmd, angular_cmd, button_level, front_range_mm, rear_range_mm, pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // right_drive, left_drive, active_source, forward_blocked, reverse_blocked
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0] manual_gain_reg;
    logic [CFG_W-1:0] auto_gain_reg;
    logic [CFG_W-1:0] timeout_reg;
    logic [CFG_W-1:0] safety_reg;
    logic             flip_turn_reg;

    op_t                     op;
    logic signed [CMD_W-1:0] linear_cmd;
    logic signed [CMD_W-1:0] angular_cmd;
    logic                    button_level;
    logic [RANGE_W-1:0]      front_range_mm;
    logic [RANGE_W-1:0]      rear_range_mm;
    logic                    req_accept;
    sel_t                    sel;
    mul_req_t                mul_req;
    logic signed [PROD_W-1:0] prod;
    result_t                 res;

    assign op             = op_t'(s_tuser);
    assign linear_cmd     = s_tdata[15:0];
    assign angular_cmd    = s_tdata[31:16];
    assign button_level   = s_tdata[32];
    assign front_range_mm = s_tdata[48:33];
    assign rear_range_mm  = s_tdata[64:49];
    assign req_accept     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_gain_reg <= MANUAL_GAIN_RST;
            auto_gain_reg   <= AUTO_GAIN_RST;
            timeout_reg     <= TIMEOUT_RST;
            safety_reg      <= SAFETY_RST;
            flip_turn_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MANUAL_GAIN: manual_gain_reg <= cfg_wdata;
                CFG_AUTO_GAIN:   auto_gain_reg   <= cfg_wdata;
                CFG_TIMEOUT:     timeout_reg     <= cfg_wdata;
                CFG_SAFETY:      safety_reg      <= cfg_wdata;
                CFG_FLIP_TURN:   flip_turn_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    dcam_state u_state (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_accept    (req_accept),
        .op            (op),
        .linear_cmd    (linear_cmd),
        .angular_cmd   (angular_cmd),
        .button_level  (button_level),
        .manual_gain   (manual_gain_reg),
        .auto_gain     (auto_gain_reg),
        .timeout_ticks (timeout_reg),
        .sel           (sel)
    );

    dcam_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    dcam_seq u_seq (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (s_tvalid),
        .in_ready           (s_tready),
        .op                 (op),
        .sel                (sel),
        .front_range_mm     (front_range_mm),
        .rear_range_mm      (rear_range_mm),
        .safety_distance_mm (safety_reg),
        .flip_turn          (flip_turn_reg),
        .mul_req            (mul_req),
        .prod               (prod),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_res            (res)
    );

    assign m_tdata = {res.reverse_blocked, res.forward_blocked, res.active_source,
                      res.left_drive, res.right_drive};

endmodule

/* rtl/core/dcam_mul.sv */
// ----------------------------------------------------------------------------
// dcam_mul: shared signed multiplier
// One signed multiply per enabled cycle, product registered and held for the
// sequencer to shift and, for speed and turn, to clamp.
// ----------------------------------------------------------------------------
module dcam_mul import dcam_pkg::*; (
    input  logic                     aclk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(req.a) * PROD_W'(req.b);

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/dcam_state.sv */
// ----------------------------------------------------------------------------
// dcam_state: command store and mode state
// Keeps the last command and age of each source, the stop and auto-mode
// flags, and picks the fresh command of the active mode for a tick.
// ----------------------------------------------------------------------------
module dcam_state import dcam_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    req_accept,
    input  op_t                     op,
    input  logic signed [CMD_W-1:0] linear_cmd,
    input  logic signed [CMD_W-1:0] angular_cmd,
    input  logic                    button_level,
    input  logic [CFG_W-1:0]        manual_gain,
    input  logic [CFG_W-1:0]        auto_gain,
    input  logic [CFG_W-1:0]        timeout_ticks,
    output sel_t                    sel
);

    logic signed [CMD_W-1:0] manual_speed_reg, manual_speed_next;
    logic signed [CMD_W-1:0] manual_turn_reg, manual_turn_next;
    logic signed [CMD_W-1:0] auto_speed_reg, auto_speed_next;
    logic signed [CMD_W-1:0] auto_turn_reg, auto_turn_next;
    logic [AGE_W-1:0]        manual_age_reg, manual_age_next;
    logic [AGE_W-1:0]        auto_age_reg, auto_age_next;
    logic                    stop_reg, stop_next;
    logic                    auto_mode_reg, auto_mode_next;

    always_comb begin
        manual_speed_next = manual_speed_reg;
        manual_turn_next  = manual_turn_reg;
        auto_speed_next   = auto_speed_reg;
        auto_turn_next    = auto_turn_reg;
        manual_age_next   = manual_age_reg;
        auto_age_next     = auto_age_reg;
        stop_next         = stop_reg;
        auto_mode_next    = auto_mode_reg;
        if (req_accept) begin
            case (op)
                OP_MANUAL: begin
                    manual_speed_next = linear_cmd;
                    manual_turn_next  = angular_cmd;
                    manual_age_next   = '0;
                end
                OP_AUTO: begin
                    auto_speed_next = linear_cmd;
                    auto_turn_next  = angular_cmd;
                    auto_age_next   = '0;
                end
                OP_STOP: begin
                    stop_next = button_level;
                    if (button_level) begin
                        manual_speed_next = '0;
                        manual_turn_next  = '0;
                        auto_speed_next   = '0;
                        auto_turn_next    = '0;
                    end
                end
                OP_MODE: begin
                    auto_mode_next = button_level;
                    if (!button_level) begin
                        auto_speed_next = '0;
                        auto_turn_next  = '0;
                    end
                end
                OP_TICK: begin
                    // age after the freshness check, saturate at the top
                    if (manual_age_reg != AGE_MAX) begin
                        manual_age_next = manual_age_reg + AGE_W'(1);
                    end
                    if (auto_age_reg != AGE_MAX) begin
                        auto_age_next = auto_age_reg + AGE_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_speed_reg <= '0;
            manual_turn_reg  <= '0;
            auto_speed_reg   <= '0;
            auto_turn_reg    <= '0;
            manual_age_reg   <= '0;
            auto_age_reg     <= '0;
            stop_reg         <= 1'b1;
            auto_mode_reg    <= 1'b1;
        end else begin
            manual_speed_reg <= manual_speed_next;
            manual_turn_reg  <= manual_turn_next;
            auto_speed_reg   <= auto_speed_next;
            auto_turn_reg    <= auto_turn_next;
            manual_age_reg   <= manual_age_next;
            auto_age_reg     <= auto_age_next;
            stop_reg         <= stop_next;
            auto_mode_reg    <= auto_mode_next;
        end
    end

    // no fallback: a stale active source gives zero
    always_comb begin
        sel = '{speed: '0, turn: '0, scale: '0, src: SRC_NONE};
        if (!stop_reg) begin
            if (auto_mode_reg && (auto_age_reg < timeout_ticks)) begin
                sel = '{speed: auto_speed_reg, turn: auto_turn_reg,
                        scale: auto_gain, src: SRC_AUTO};
            end else if (!auto_mode_reg && (manual_age_reg < timeout_ticks)) begin
                sel = '{speed: manual_speed_reg, turn: manual_turn_reg,
                        scale: manual_gain, src: SRC_MANUAL};
            end
        end
    end

endmodule

/* rtl/core/dcam_seq.sv */
// ----------------------------------------------------------------------------
// dcam_seq: tick sequencer and output register
// Steps one tick through scale, block, clamp and mix on the shared
// multiplier, then holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module dcam_seq import dcam_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  op_t                      op,
    input  sel_t                     sel,
    input  logic [RANGE_W-1:0]       front_range_mm,
    input  logic [RANGE_W-1:0]       rear_range_mm,
    input  logic [CFG_W-1:0]         safety_distance_mm,
    input  logic                     flip_turn,
    output mul_req_t                 mul_req,
    input  logic signed [PROD_W-1:0] prod,
    output logic                     out_valid,
    input  logic                     out_ready,
    output result_t                  out_res
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SPEED = 7'b0000010,
        S_TURN  = 7'b0000100,
        S_WZ    = 7'b0001000,
        S_RIGHT = 7'b0010000,
        S_LEFT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    localparam logic signed [SHR_W-1:0] POS_ONE = SHR_W'(ONE_Q);
    localparam logic signed [SHR_W-1:0] NEG_ONE = -POS_ONE;

    function automatic logic signed [VAL_W-1:0] clamp_one(input logic signed [SHR_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > POS_ONE) begin
            r = POS_ONE[VAL_W-1:0];
        end else if (v < NEG_ONE) begin
            r = NEG_ONE[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    state_t                  state_reg, state_next;
    sel_t                    sel_reg;
    logic                    near_front_reg, near_rear_reg;
    logic signed [VAL_W-1:0] vx_reg, wz_reg;
    logic                    fblk_reg, rblk_reg;
    logic signed [DRIVE_W-1:0] right_reg;
    logic                    out_valid_reg;
    result_t                 out_res_reg;

    logic                    accept;
    logic                    out_load;
    logic signed [SHR_W-1:0] prod_shr;
    logic signed [VAL_W-1:0] wz_clamp;
    logic signed [SUM_W-1:0] mix_sum, mix_diff;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // floor shift: arithmetic shift of the two's complement product
    assign prod_shr = prod[PROD_W-1:FRAC_BITS];
    assign wz_clamp = clamp_one(prod_shr);
    assign mix_sum  = SUM_W'(vx_reg) + SUM_W'(wz_reg);
    assign mix_diff = SUM_W'(vx_reg) - SUM_W'(wz_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept && (op == OP_TICK)) state_next = S_SPEED;
            S_SPEED: state_next = S_TURN;
            S_TURN:  state_next = S_WZ;
            S_WZ:    state_next = S_RIGHT;
            S_RIGHT: state_next = S_LEFT;
            S_LEFT:  state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mul_req.en = 1'b0;
        mul_req.a  = MUL_A_W'(sel_reg.speed);
        mul_req.b  = $signed({1'b0, sel_reg.scale});
        case (state_reg)
            S_SPEED: mul_req.en = 1'b1;
            S_TURN: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(sel_reg.turn);
            end
            S_RIGHT: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(mix_sum);
                mul_req.b  = MUL_B_W'(MIX_GAIN);
            end
            S_LEFT: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(mix_diff);
                mul_req.b  = MUL_B_W'(MIX_GAIN);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sel_reg        <= sel;
            near_front_reg <= (front_range_mm <= safety_distance_mm);
            near_rear_reg  <= (rear_range_mm <= safety_distance_mm);
        end
        if (state_reg == S_TURN) begin
            // drop motion toward a near obstacle before the clamp
            fblk_reg <= 1'b0;
            rblk_reg <= 1'b0;
            if (!prod_shr[SHR_W-1] && (prod_shr != '0) && near_front_reg) begin
                vx_reg   <= '0;
                fblk_reg <= 1'b1;
            end else if (prod_shr[SHR_W-1] && near_rear_reg) begin
                vx_reg   <= '0;
                rblk_reg <= 1'b1;
            end else begin
                vx_reg <= clamp_one(prod_shr);
            end
        end
        if (state_reg == S_WZ) begin
            wz_reg <= flip_turn ? -wz_clamp : wz_clamp;
        end
        if (state_reg == S_LEFT) begin
            right_reg <= prod_shr[DRIVE_W-1:0];
        end
        if (out_load) begin
            out_res_reg.right_drive     <= right_reg;
            out_res_reg.left_drive      <= prod_shr[DRIVE_W-1:0];
            out_res_reg.active_source   <= sel_reg.src;
            out_res_reg.forward_blocked <= fblk_reg;
            out_res_reg.reverse_blocked <= rblk_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

/* rtl/core/dcam_checker.sv */
// ----------------------------------------------------------------------------
// dcam_checker: port-level assertions for the drive command arbiter mixer
// Watches the top-level ports for reset behavior, result holding, drive
// range, blocking flags and the busy window after a tick.
// ----------------------------------------------------------------------------
module dcam_checker import dcam_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [OP_W-1:0]      s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [DRIVE_W-1:0] left_drive;

    assign right_drive = m_tdata[13:0];
    assign left_drive  = m_tdata[27:14];

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (right_drive <= 14'sd6554) && (right_drive >= -14'sd6554) &&
                     (left_drive <= 14'sd6554) && (left_drive >= -14'sd6554))
        else $error("drive value outside +/-0.8 of full scale");

    a_block_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[30] || m_tdata[31]) |->
            !(m_tdata[30] && m_tdata[31]) && (m_tdata[29:28] != SRC_NONE))
        else $error("blocking flag without an active source or both set");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_TICK) |=> !s_tready)
        else $error("request taken while a tick is in progress");

endmodule

bind drive_command_arbiter_mixer dcam_checker u_dcam_checker (.*);

/* bench/drive_mix_checker.sv */
// ----------------------------------------------------------------------------
// drive_mix_checker: scoreboard for the drive command arbiter mixer
// Watches the request stream, the result stream and the register write port,
// keeps its own copy of the commands, ages, modes and registers, predicts
// the wheel drives of every control tick and compares them in order.
// ----------------------------------------------------------------------------
module drive_mix_checker import dcam_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // linear_cmd, angular_cmd, button_level, front_range_mm, rear_range_mm, pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // right_drive, left_drive, active_source, forward_blocked, reverse_blocked
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   fail_count,
    output int                   open_results
);

    localparam longint UNIT     = longint'(1) << FRAC_BITS;
    localparam longint WHEEL_MIX = ((longint'(8) << FRAC_BITS) + 5) / 10;

    // same bit order as the result stream, lowest field last
    typedef struct packed {
        logic                      rev_blk;
        logic                      fwd_blk;
        src_t                      src;
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
    } drive_t;

    logic [CFG_W-1:0]        manual_gain, auto_gain, timeout, safety_mm;
    logic                    flip;
    logic signed [CMD_W-1:0] man_speed, man_turn, aut_speed, aut_turn;
    logic [AGE_W-1:0]        man_age, aut_age;
    logic                    stopped, auto_on;
    drive_t                  drives_due[$];

    initial begin
        fail_count   = 0;
        open_results = 0;
    end

    function automatic longint gain_mul(logic signed [CMD_W-1:0] v, logic [CFG_W-1:0] g);
        return (longint'(v) * longint'(g)) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    function automatic drive_t compute_drive(logic [RANGE_W-1:0] front, logic [RANGE_W-1:0] rear);
        longint vx, wz, mix;
        drive_t d;
        vx = 0;
        wz = 0;
        d  = '0;
        // no fallback to the other source when the active one is stale
        if (!stopped) begin
            if (auto_on && aut_age < timeout) begin
                vx    = gain_mul(aut_speed, auto_gain);
                wz    = gain_mul(aut_turn, auto_gain);
                d.src = SRC_AUTO;
            end else if (!auto_on && man_age < timeout) begin
                vx    = gain_mul(man_speed, manual_gain);
                wz    = gain_mul(man_turn, manual_gain);
                d.src = SRC_MANUAL;
            end
        end
        if (vx > 0 && front <= safety_mm) begin
            vx        = 0;
            d.fwd_blk = 1'b1;
        end else if (vx < 0 && rear <= safety_mm) begin
            vx        = 0;
            d.rev_blk = 1'b1;
        end
        vx = clamp_unit(vx);
        wz = clamp_unit(wz);
        if (flip) wz = -wz;
        mix     = ((vx + wz) * WHEEL_MIX) >>> FRAC_BITS;
        d.right = mix[DRIVE_W-1:0];
        mix     = ((vx - wz) * WHEEL_MIX) >>> FRAC_BITS;
        d.left  = mix[DRIVE_W-1:0];
        return d;
    endfunction

    always @(posedge aclk) begin : watch
        drive_t got, want;
        if (!aresetn) begin
            manual_gain = MANUAL_GAIN_RST;
            auto_gain   = AUTO_GAIN_RST;
            timeout     = TIMEOUT_RST;
            safety_mm   = SAFETY_RST;
            flip        = 1'b0;
            man_speed   = '0;
            man_turn    = '0;
            aut_speed   = '0;
            aut_turn    = '0;
            man_age     = '0;
            aut_age     = '0;
            stopped     = 1'b1;
            auto_on     = 1'b1;
            drives_due.delete();
        end else begin
            // take the result first: a tick accepted on this edge is never its source
            if (m_tvalid && m_tready) begin
                got = drive_t'(m_tdata);
                if (drives_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"drive result error: no tick pending, ",
                                  "got R=%0d L=%0d src=%0d fb=%0b rb=%0b"},
                                 got.right, got.left, got.src, got.fwd_blk, got.rev_blk);
                end else begin
                    want = drives_due.pop_front();
                    if (got.right !== want.right || got.left !== want.left ||
                        got.src !== want.src || got.fwd_blk !== want.fwd_blk ||
                        got.rev_blk !== want.rev_blk) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"drive result error: ",
                                      "exp R=%0d L=%0d src=%0d fb=%0b rb=%0b, ",
                                      "got R=%0d L=%0d src=%0d fb=%0b rb=%0b"},
                                     want.right, want.left, want.src, want.fwd_blk,
                                     want.rev_blk, got.right, got.left, got.src,
                                     got.fwd_blk, got.rev_blk);
                    end
                end
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MANUAL_GAIN: manual_gain = cfg_wdata;
                    CFG_AUTO_GAIN:   auto_gain   = cfg_wdata;
                    CFG_TIMEOUT:     timeout     = cfg_wdata;
                    CFG_SAFETY:      safety_mm   = cfg_wdata;
                    CFG_FLIP_TURN:   flip        = cfg_wdata[0];
                    default: ;
                endcase
            end

            // request layout: lin [15:0], ang [31:16], level [32], front [48:33], rear [64:49]
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_MANUAL: begin
                        man_speed = s_tdata[15:0];
                        man_turn  = s_tdata[31:16];
                        man_age   = '0;
                    end
                    OP_AUTO: begin
                        aut_speed = s_tdata[15:0];
                        aut_turn  = s_tdata[31:16];
                        aut_age   = '0;
                    end
                    OP_STOP: begin
                        stopped = s_tdata[32];
                        if (s_tdata[32]) begin
                            man_speed = '0;
                            man_turn  = '0;
                            aut_speed = '0;
                            aut_turn  = '0;
                        end
                    end
                    OP_MODE: begin
                        auto_on = s_tdata[32];
                        if (!s_tdata[32]) begin
                            aut_speed = '0;
                            aut_turn  = '0;
                        end
                    end
                    OP_TICK: begin
                        drives_due.push_back(compute_drive(s_tdata[48:33], s_tdata[64:49]));
                        if (man_age != AGE_MAX) man_age++;
                        if (aut_age != AGE_MAX) aut_age++;
                    end
                    default: ;
                endcase
            end
        end
        open_results = drives_due.size();
    end

endmodule

/* bench/drive_command_arbiter_mixer_tb.sv */
// ----------------------------------------------------------------------------
// drive_command_arbiter_mixer_tb: stimulus and verdict for the drive mixer
// Drives directed and random command, button and tick requests through several
// register settings and idling regimes, runs a short tick stretch past the
// timeout, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module drive_command_arbiter_mixer_tb;
    import dcam_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 125;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int open_results;
    int send_idle_pct = 7;
    int recv_idle_pct = 67;
    int safety_mm     = 300;
    int quiet_cycles  = 0;

    drive_command_arbiter_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    drive_mix_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .open_results (open_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("drive_command_arbiter_mixer: mismatch");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_request(input logic [OP_W-1:0] op, input logic [CMD_W-1:0] lin,
                                input logic [CMD_W-1:0] ang, input logic lvl,
                                input logic [RANGE_W-1:0] front,
                                input logic [RANGE_W-1:0] rear);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {7'b0, rear, front, lvl, ang, lin};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // hold requests until every tick result is back, then wait out the tail
    task automatic settle(input int extra);
        s_tvalid = 1'b0;
        while (open_results != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic load_setting(input logic [CFG_W-1:0] man_g, input logic [CFG_W-1:0] aut_g,
                                input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] safe,
                                input logic flip);
        cfg_idx_t         idx[5];
        logic [CFG_W-1:0] val[5];
        idx = '{CFG_MANUAL_GAIN, CFG_AUTO_GAIN, CFG_TIMEOUT, CFG_SAFETY, CFG_FLIP_TURN};
        val = '{man_g, aut_g, tmo, safe, CFG_W'(flip)};
        settle(DRAIN_CYCLES);
        cfg_wr_en = 1'b1;
        for (int i = 0; i < 5; i++) begin
            cfg_index = idx[i];
            cfg_wdata = val[i];
            @(negedge aclk);
        end
        cfg_wr_en = 1'b0;
        safety_mm = int'(safe);
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd();
        if ($urandom_range(2) == 0) return CMD_W'($urandom);
        return CMD_W'($urandom_range(12000) - 6000);
    endfunction

    // favor ranges around the safety distance so blocking toggles often
    function automatic logic [RANGE_W-1:0] pick_range();
        int v;
        case ($urandom_range(3))
            0: begin
                v = $urandom_range(4);
                v = v + safety_mm - 2;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return RANGE_W'(v);
            end
            1: return RANGE_W'($urandom_range(2000));
            default: return RANGE_W'($urandom);
        endcase
    endfunction

    task automatic random_request(output bit counted);
        int              pick;
        logic [OP_W-1:0] op;
        logic            lvl;
        pick = $urandom_range(99);
        if (pick < 45)      op = OP_TICK;
        else if (pick < 60) op = OP_MANUAL;
        else if (pick < 75) op = OP_AUTO;
        else if (pick < 84) op = OP_STOP;
        else if (pick < 93) op = OP_MODE;
        else                op = OP_W'(OP_TICK + 1 + $urandom_range(2));
        // keep stop mostly released so ticks reach the mixer
        lvl = (op == OP_STOP) ? ($urandom_range(99) < 30) : 1'($urandom_range(1));
        push_request(op, pick_cmd(), pick_cmd(), lvl, pick_range(), pick_range());
        counted = (op <= OP_TICK);
    endtask

    initial begin : stimulus
        bit counted;
        int done;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part on reset register values
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF);
        push_request(OP_MANUAL, 16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF);
        push_request(OP_STOP,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF);
        push_request(OP_AUTO,   16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'hFFFF);
        push_request(OP_AUTO,   16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 16'd300);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'd301, 16'd301);
        push_request(OP_MODE,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF);
        push_request(OP_MANUAL, 16'd1000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b1, 16'd300, 16'd300);
        push_request(OP_MODE,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000);
        push_request(OP_AUTO,   16'hFFFF, 16'h0001, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_STOP,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF);
        for (int u = OP_TICK + 1; u < (1 << OP_W); u++)
            push_request(OP_W'(u), 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        push_request(OP_STOP,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_TICK,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_setting(16'd0, 16'd0, 16'd1, 16'd0, 1'b0);
                1: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                2: load_setting(CFG_W'($urandom_range(16384)), CFG_W'($urandom_range(16384)),
                                CFG_W'($urandom_range(40, 1)), CFG_W'($urandom_range(2000)),
                                1'($urandom_range(1)));
                3: load_setting(16'd4096, 16'd8192, 16'd0, 16'd300, 1'b1);
                4: load_setting(16'd1638, 16'd6144, 16'd20, 16'd300, 1'b0);
                default: load_setting(CFG_W'($urandom), CFG_W'($urandom),
                                      CFG_W'($urandom_range(10, 1)),
                                      CFG_W'($urandom_range(1000)), 1'($urandom_range(1)));
            endcase
            send_idle_pct = (phase < 2) ? 7 : (phase < 4) ? 67 : 0;
            recv_idle_pct = (phase < 2) ? 67 : (phase < 4) ? 7 : 0;
            done = 0;
            while (done < PHASE_ITEMS) begin
                if (phase == 0 && done == PHASE_ITEMS / 2) settle(0);
                random_request(counted);
                if (counted) done++;
            end
        end

        // run past a short timeout: the command must go stale and stay stale
        load_setting(16'd4096, 16'd4096, 16'd3, 16'd0, 1'b0);
        push_request(OP_STOP,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_MODE,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        push_request(OP_MANUAL, 16'd2000, 16'hFD44, 1'b0, 16'h0000, 16'h0000);
        repeat (6)
            push_request(OP_TICK, 16'h0000, 16'h0000, 1'b0, RANGE_W'($urandom),
                         RANGE_W'($urandom));

        settle(DRAIN_CYCLES);
        if (fail_count == 0 && open_results == 0)
            $display("drive_command_arbiter_mixer: match");
        else
            $display("drive_command_arbiter_mixer: mismatch");
        $finish;
    end

endmodule
